@@ hdl/mals_pkg.sv @@
// shared constants, types and divider tables for the meridian arc length unit
package mals_pkg;

    localparam int LAT_W        = 32;
    localparam int OUT_W        = 35;
    localparam int OUT_TDATA_W  = 40;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 39;
    localparam int SINE_STAGES  = 18;
    localparam int HORNER_STEPS = 6;

    localparam logic signed [31:0] LAT_LIMIT = 32'sd1686629713;
    localparam logic signed [31:0] LAT_FLOOR = -32'sd1686629713;
    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
    localparam logic [29:0] TWO_PI_Q27      = 30'd843314857;
    localparam logic [31:0] ONE_Q31         = 32'h8000_0000;

    localparam logic [38:0] LINEAR_RESET = 39'd417297147219;
    localparam logic [31:0] SIN2_RESET   = 32'd1051099791;
    localparam logic [23:0] SIN4_RESET   = 24'd1102970;
    localparam logic [15:0] SIN6_RESET   = 16'd1441;
    localparam logic [7:0]  SIN8_RESET   = 8'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINEAR = 3'd0,
        CFG_SIN2   = 3'd1,
        CFG_SIN4   = 3'd2,
        CFG_SIN6   = 3'd3,
        CFG_SIN8   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        flip;
        logic [31:0] mag;
    } sine_out_t;

    // horner divisors as (y >> shr) * rcp >> k, row 0 sine, row 1 cosine
    // sine: bypass, 110, 72, 42, 20, 6   cosine: 132, 90, 56, 30, 12, 2
    localparam logic [1:0] DIV_SHR [2][6] = '{
        '{2'd0, 2'd1, 2'd3, 2'd1, 2'd2, 2'd1},
        '{2'd2, 2'd1, 2'd3, 2'd1, 2'd2, 2'd1}
    };
    localparam logic [5:0] DIV_K [2][6] = '{
        '{6'd31, 6'd37, 6'd35, 6'd36, 6'd34, 6'd33},
        '{6'd37, 6'd37, 6'd34, 6'd35, 6'd33, 6'd31}
    };
    localparam logic [31:0] DIV_RCP [2][6] = '{
        '{32'd0,
          32'(((64'd1 << 37) + 64'd54) / 64'd55),
          32'(((64'd1 << 35) + 64'd8) / 64'd9),
          32'(((64'd1 << 36) + 64'd20) / 64'd21),
          32'(((64'd1 << 34) + 64'd4) / 64'd5),
          32'(((64'd1 << 33) + 64'd2) / 64'd3)},
        '{32'(((64'd1 << 37) + 64'd32) / 64'd33),
          32'(((64'd1 << 37) + 64'd44) / 64'd45),
          32'(((64'd1 << 34) + 64'd6) / 64'd7),
          32'(((64'd1 << 35) + 64'd14) / 64'd15),
          32'(((64'd1 << 33) + 64'd2) / 64'd3),
          32'h8000_0000}
    };

endpackage

@@ hdl/mals_sine.sv @@
// pipelined fixed point sine of a phase in 2^-64 turn units
module mals_sine
    import mals_pkg::*;
(
    input  logic                   clk,
    input  logic [SINE_STAGES-1:0] en,
    input  logic [63:0]            phase,
    output sine_out_t              result
);

    typedef struct packed {
        logic [30:0] x;
        logic [30:0] x2;
        logic        cos_mode;
        logic        flip;
    } carry_t;

    logic [63:0] f_reg;
    logic [1:0]  q_reg;
    logic [61:0] m_reg;
    logic [62:0] xp_reg;
    logic [61:0] sq_reg;
    carry_t      ctl_reg [1:16];
    logic [30:0] y_reg [HORNER_STEPS];
    logic [62:0] prod_reg [HORNER_STEPS];
    sine_out_t   result_reg;

    logic [1:0]  q_fold;
    logic [63:0] f_abs;
    logic [62:0] x_sum;
    logic [30:0] x_c;
    logic [62:0] sq_sum;
    carry_t      c1_next;
    carry_t      c3_next;
    carry_t      c4_next;
    logic [31:0] t_in [HORNER_STEPS];
    logic [62:0] ymul [HORNER_STEPS];
    logic [30:0] ysh [HORNER_STEPS];
    logic [62:0] prod_next [HORNER_STEPS];
    logic [31:0] t_fin;
    logic [62:0] rmul;
    sine_out_t   result_next;

    // next horner factor from the scaled quotient product
    function automatic logic [31:0] step_t(input logic [62:0] prod, input logic cos_mode,
                                           input int step);
        logic [62:0] quo;
        begin
            quo = prod >> DIV_K[cos_mode][step];
            if (!cos_mode && step == 0)
                step_t = ONE_Q31;
            else
                step_t = ONE_Q31 - quo[31:0];
        end
    endfunction

    always_comb
    begin
        // fold to the nearest quarter turn
        q_fold = phase[63:62] + {1'b0, phase[61]};
        f_abs  = f_reg[63] ? (64'd0 - f_reg) : f_reg;

        c1_next          = '0;
        c1_next.cos_mode = q_reg[0];
        c1_next.flip     = (!q_reg[0] && f_reg[63]) ^ q_reg[1];

        x_sum      = xp_reg + 63'(64'd1 << 30);
        x_c        = x_sum[61:31];
        c3_next    = ctl_reg[2];
        c3_next.x  = x_c;

        sq_sum     = 63'(sq_reg) + 63'(64'd1 << 30);
        c4_next    = ctl_reg[3];
        c4_next.x2 = sq_sum[61:31];

        t_in[0] = ONE_Q31;
        for (int j = 1; j < HORNER_STEPS; j++)
            t_in[j] = step_t(prod_reg[j-1], ctl_reg[4+2*j].cos_mode, j - 1);
        for (int j = 0; j < HORNER_STEPS; j++)
        begin
            ymul[j]      = 63'(ctl_reg[4+2*j].x2) * 63'(t_in[j]);
            ysh[j]       = y_reg[j] >> DIV_SHR[ctl_reg[5+2*j].cos_mode][j];
            prod_next[j] = 63'(ysh[j]) * 63'(DIV_RCP[ctl_reg[5+2*j].cos_mode][j]);
        end

        t_fin = step_t(prod_reg[HORNER_STEPS-1], ctl_reg[16].cos_mode, HORNER_STEPS - 1);
        rmul  = 63'(ctl_reg[16].x) * 63'(t_fin);
        result_next.flip = ctl_reg[16].flip;
        result_next.mag  = ctl_reg[16].cos_mode ? t_fin : rmul[62:31];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            f_reg <= {phase[63:62] - q_fold, phase[61:0]};
            q_reg <= q_fold;
        end
        if (en[1])
        begin
            m_reg      <= f_abs[61:0];
            ctl_reg[1] <= c1_next;
        end
        if (en[2])
        begin
            xp_reg     <= 63'(m_reg[61:29]) * 63'(TWO_PI_Q27);
            ctl_reg[2] <= ctl_reg[1];
        end
        if (en[3])
        begin
            sq_reg     <= 62'(x_c) * 62'(x_c);
            ctl_reg[3] <= c3_next;
        end
        if (en[4])
            ctl_reg[4] <= c4_next;
        for (int s = 5; s <= 16; s++)
            if (en[s])
                ctl_reg[s] <= ctl_reg[s-1];
        for (int j = 0; j < HORNER_STEPS; j++)
        begin
            if (en[5+2*j])
                y_reg[j] <= ymul[j][61:31];
            if (en[6+2*j])
                prod_reg[j] <= prod_next[j];
        end
        if (en[17])
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

@@ hdl/meridian_arc_length_series_unit.sv @@
// meridian arc length series unit, top level
//
// s_tdata carries a latitude in signed Q2.30 radians; m_tdata returns the
// meridian arc length from the equator in signed millimetres, one result
// beat for every input beat, in order. Latitudes past the poles are
// clamped to plus or minus pi/2.
// The five series coefficients are written through the cfg port (index
// 0 linear, 1..4 the sin 2B..8B terms); cfg_ready is always high and
// writes to unused indexes are dropped. Write them only while idle.
// The datapath is a 26-stage register pipeline, and a new latitude is
// taken every cycle while m_tready is high.
// The depth is set by the six-step horner chain of the sine units, each
// step a multiply and a reciprocal multiply in stages of their own.
// Each stage has a valid bit and moves when the stage after it is empty
// or moving, so bubbles close up while m_tready is low and input is still
// taken until every stage holds a beat.
// Reset clears all valid bits and loads the default coefficients.
module meridian_arc_length_series_unit
    import mals_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [LAT_W-1:0]       s_tdata,    // [31:0] latitude
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,    // [34:0] arc_length, [39:35] zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int NSTG      = 26;
    localparam int ST_IN     = 0;
    localparam int ST_MUL    = 1;
    localparam int ST_SINE   = 2;
    localparam int ST_TERM   = ST_SINE + SINE_STAGES;
    localparam int ST_PART   = ST_TERM + 1;
    localparam int ST_SUM    = ST_TERM + 2;
    localparam int ST_ABS    = ST_TERM + 3;
    localparam int ST_MM     = ST_TERM + 4;
    localparam int ST_OUT    = ST_TERM + 5;

    logic [38:0] linear_coeff_reg;
    logic [31:0] sin2_coeff_reg;
    logic [23:0] sin4_coeff_reg;
    logic [15:0] sin6_coeff_reg;
    logic [7:0]  sin8_coeff_reg;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    logic signed [31:0] b_reg;
    logic [30:0]        ub_reg;
    logic               neg0_reg;
    logic [63:0]        phase_reg;
    logic [49:0]        hi_reg;
    logic [50:0]        lo_reg;
    logic               neg1_reg;
    logic [54:0]        lin_d [ST_SINE:ST_TERM-1];
    logic               neg_d [ST_SINE:ST_TERM-1];
    logic [55:0]        lin_reg;
    logic [63:0]        p2_reg;
    logic [55:0]        p4_reg;
    logic [47:0]        p6_reg;
    logic [39:0]        p8_reg;
    logic [3:0]         flip_reg;
    logic [55:0]        pa_reg;
    logic [55:0]        pb_reg;
    logic [55:0]        sum_reg;
    logic [54:0]        u_reg;
    logic               negu_reg;
    logic [34:0]        hp_reg;
    logic [39:0]        lp_reg;
    logic               negm_reg;
    logic [OUT_W-1:0]   mm_reg;

    logic signed [31:0] lat;
    logic signed [31:0] b_next;
    logic [31:0]        b_abs;
    logic signed [64:0] phase_full;
    logic [54:0]        lin_next;
    logic [63:0]        k2p;
    logic [63:0]        k4p;
    logic [63:0]        k6p;
    logic [63:0]        k8p;
    sine_out_t          s2;
    sine_out_t          s4;
    sine_out_t          s6;
    sine_out_t          s8;
    logic [55:0]        v2;
    logic [55:0]        v4;
    logic [55:0]        v6;
    logic [55:0]        v8;
    logic [55:0]        sum_abs;
    logic [34:0]        mm_mag;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_coeff_reg <= LINEAR_RESET;
            sin2_coeff_reg   <= SIN2_RESET;
            sin4_coeff_reg   <= SIN4_RESET;
            sin6_coeff_reg   <= SIN6_RESET;
            sin8_coeff_reg   <= SIN8_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LINEAR: linear_coeff_reg <= cfg_data;
                CFG_SIN2:   sin2_coeff_reg   <= cfg_data[31:0];
                CFG_SIN4:   sin4_coeff_reg   <= cfg_data[23:0];
                CFG_SIN6:   sin6_coeff_reg   <= cfg_data[15:0];
                CFG_SIN8:   sin8_coeff_reg   <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // stage enables: a stage moves when it is empty or the next one moves
    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= s_tvalid;
            for (int i = 1; i < NSTG; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    assign s_tready = en[ST_IN];
    assign m_tvalid = v_reg[ST_OUT];
    assign m_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, mm_reg};

    // datapath
    always_comb
    begin
        lat = $signed(s_tdata);
        if (lat > LAT_LIMIT)
            b_next = LAT_LIMIT;
        else if (lat < LAT_FLOOR)
            b_next = LAT_FLOOR;
        else
            b_next = lat;
        b_abs = b_next[31] ? (32'd0 - b_next) : b_next;

        phase_full = b_reg * $signed({1'b0, TWO_OVER_PI_Q32});
        lin_next   = {1'b0, hi_reg, 4'b0} + 55'(lo_reg >> 16);

        k2p = phase_reg << 1;
        k4p = phase_reg << 2;
        k8p = phase_reg << 3;
        k6p = (phase_reg << 2) + (phase_reg << 1);

        v2 = 56'(p2_reg >> 17);
        v4 = 56'(p4_reg >> 17);
        v6 = 56'(p6_reg >> 17);
        v8 = 56'(p8_reg >> 17);

        sum_abs = sum_reg[55] ? (56'd0 - sum_reg) : sum_reg;
        mm_mag  = hp_reg + {25'b0, lp_reg[39:30]};
    end

    mals_sine u_sine2 (.clk(clk), .en(en[ST_SINE +: SINE_STAGES]), .phase(k2p), .result(s2));
    mals_sine u_sine4 (.clk(clk), .en(en[ST_SINE +: SINE_STAGES]), .phase(k4p), .result(s4));
    mals_sine u_sine6 (.clk(clk), .en(en[ST_SINE +: SINE_STAGES]), .phase(k6p), .result(s6));
    mals_sine u_sine8 (.clk(clk), .en(en[ST_SINE +: SINE_STAGES]), .phase(k8p), .result(s8));

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            b_reg    <= b_next;
            ub_reg   <= b_abs[30:0];
            neg0_reg <= b_next[31];
        end
        if (en[ST_MUL])
        begin
            phase_reg <= phase_full[63:0];
            hi_reg    <= 50'(ub_reg) * 50'(linear_coeff_reg[38:20]);
            lo_reg    <= 51'(ub_reg) * 51'(linear_coeff_reg[19:0]);
            neg1_reg  <= neg0_reg;
        end
        // linear term waits alongside the sine units
        if (en[ST_SINE])
        begin
            lin_d[ST_SINE] <= lin_next;
            neg_d[ST_SINE] <= neg1_reg;
        end
        for (int i = ST_SINE + 1; i < ST_TERM; i++)
            if (en[i])
            begin
                lin_d[i] <= lin_d[i-1];
                neg_d[i] <= neg_d[i-1];
            end
        if (en[ST_TERM])
        begin
            lin_reg  <= neg_d[ST_TERM-1] ? (56'd0 - {1'b0, lin_d[ST_TERM-1]})
                                         : {1'b0, lin_d[ST_TERM-1]};
            p2_reg   <= 64'(sin2_coeff_reg) * 64'(s2.mag);
            p4_reg   <= 56'(sin4_coeff_reg) * 56'(s4.mag);
            p6_reg   <= 48'(sin6_coeff_reg) * 48'(s6.mag);
            p8_reg   <= 40'(sin8_coeff_reg) * 40'(s8.mag);
            flip_reg <= {s8.flip, s6.flip, s4.flip, s2.flip};
        end
        // series signs: minus sin2, plus sin4, minus sin6, plus sin8
        if (en[ST_PART])
        begin
            pa_reg <= flip_reg[0] ? (lin_reg + v2) : (lin_reg - v2);
            pb_reg <= (flip_reg[1] ? (56'd0 - v4) : v4)
                    + (flip_reg[2] ? v6 : (56'd0 - v6))
                    + (flip_reg[3] ? (56'd0 - v8) : v8);
        end
        if (en[ST_SUM])
            sum_reg <= pa_reg + pb_reg;
        if (en[ST_ABS])
        begin
            u_reg    <= sum_abs[54:0];
            negu_reg <= sum_reg[55];
        end
        if (en[ST_MM])
        begin
            hp_reg   <= 35'(u_reg[54:30]) * 35'd1000;
            lp_reg   <= 40'(u_reg[29:0]) * 40'd1000 + 40'(64'd1 << 29);
            negm_reg <= negu_reg;
        end
        if (en[ST_OUT])
            mm_reg <= negm_reg ? (35'd0 - mm_mag) : mm_mag;
    end

endmodule

@@ hdl/mals_checker.sv @@
// port-level checks for the meridian arc length unit and their bind
module mals_checker
    import mals_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   cfg_ready
);

    // a waiting result beat holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // with the output free, every stage can move
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output side is free");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_W] == '0)
        else $error("tdata padding not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind meridian_arc_length_series_unit mals_checker u_mals_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
